>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; all sample on clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked in every cycle, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/brfs_pkg.sv
// ----------------------------------------------------------------------------
// brfs_pkg
// Word types, opcodes and status codes of the byte ring FIFO with search.
// ----------------------------------------------------------------------------
package brfs_pkg;

  localparam int DEPTH_DEF = 64;

  localparam logic [2:0] OP_ENQ  = 3'd0;
  localparam logic [2:0] OP_DEQ  = 3'd1;
  localparam logic [2:0] OP_PEEK = 3'd2;
  localparam logic [2:0] OP_DISC = 3'd3;
  localparam logic [2:0] OP_PUSH = 3'd4;
  localparam logic [2:0] OP_FIND = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
    logic [6:0] amount;
    logic [5:0] start_offset;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic [1:0] status;
    logic [5:0] found_offset;
    logic [6:0] fill_count;
  } out_word_t;

endpackage

>>> sv/byte_ring_fifo_with_search_top.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_top
// Circular byte FIFO with enqueue, dequeue, peek, discard, push back and find.
// ----------------------------------------------------------------------------
// One request word in, one result word out. Enqueue, push back, discard and
// the no-op codes go from EXEC straight to DONE, where the output register
// is loaded; a dequeue or peek with bytes held also passes through RDWAIT,
// because the store has a registered read port. Find walks the store through
// its single read port and one byte comparator, one byte per FRD and FCMP
// pair: it goes to DONE on a hit, or from FRD once the window is exhausted.
// A stalled output register holding the previous result delays the load.
// in_stall is high while a request is in flight; a new request is taken as
// soon as the sequencer is idle, even while the previous result is still
// held in the output register. The store powers up undefined, but no
// request ever reads an unwritten entry, so there is no clearing pass.
// fill_count reports the low 7 bits of the held count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module byte_ring_fifo_with_search_top #(
  parameter int DEPTH = brfs_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  brfs_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output brfs_pkg::out_word_t out_word
);

  import brfs_pkg::*;

  localparam int IW = $clog2(DEPTH);       // slot index
  localparam int CW = $clog2(DEPTH + 1);   // held count
  localparam int WW = ((CW > 7) ? CW : 7) + 1;  // count vs. field compares
  localparam int SW = ((IW > 7) ? IW : 7) + 1;  // index sums before wrap
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_RDWAIT, S_FRD, S_FCMP, S_DONE
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   front_r, front_nxt;   // slot just before the oldest byte
  logic [IW-1:0]   back_r, back_nxt;     // slot of the next enqueue
  logic [CW-1:0]   held_r, held_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;       // find scan slot
  logic [6:0]      x_r, x_nxt;           // find scan offset
  in_word_t        req_r, req_nxt;
  out_word_t       res_r, res_nxt;
  out_word_t       out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  logic [7:0]      wdata, rdata;
  logic            full, empty, out_load;
  logic [SW-1:0]   disc_sum, find_sum;

  function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
    return (i == LAST) ? '0 : i + 1'b1;
  endfunction

  brfs_store #(.DEPTH(DEPTH)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  assign full     = (WW'(held_r) >= WW'(DEPTH));
  assign empty    = (held_r == '0);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign disc_sum = SW'(front_r) + SW'(req_r.amount);
  assign find_sum = SW'(front_r) + SW'(1) + SW'(req_r.start_offset);

  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    held_nxt      = held_r;
    idx_nxt       = idx_r;
    x_nxt         = x_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    we            = 1'b0;
    waddr         = back_r;
    wdata         = req_r.data_byte;
    raddr         = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_word;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        res_nxt.status = ST_OK;
        state_nxt = S_DONE;
        case (req_r.opcode)
          OP_ENQ: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              we       = 1'b1;
              waddr    = back_r;
              back_nxt = next_slot(back_r);
              held_nxt = held_r + 1'b1;
            end
          end
          OP_DEQ, OP_PEEK: begin
            if (empty) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              raddr     = next_slot(front_r);
              state_nxt = S_RDWAIT;
              if (req_r.opcode == OP_DEQ) begin
                front_nxt = next_slot(front_r);
                held_nxt  = held_r - 1'b1;
              end
            end
          end
          OP_DISC: begin
            if (WW'(held_r) <= WW'(req_r.amount)) begin
              front_nxt = LAST;
              back_nxt  = '0;
              held_nxt  = '0;
            end else begin
              // amount < held <= DEPTH, so one wrap is enough
              front_nxt = (disc_sum >= SW'(DEPTH)) ? IW'(disc_sum - SW'(DEPTH))
                                                   : IW'(disc_sum);
              held_nxt  = held_r - CW'(req_r.amount);
            end
          end
          OP_PUSH: begin
            if (full) begin
              res_nxt.status = ST_FULL;
            end else begin
              we        = 1'b1;
              waddr     = front_r;
              front_nxt = (front_r == '0) ? LAST : front_r - 1'b1;
              held_nxt  = held_r + 1'b1;
            end
          end
          OP_FIND: begin
            // index only used when start lies inside the held bytes
            idx_nxt   = (find_sum >= SW'(DEPTH)) ? IW'(find_sum - SW'(DEPTH))
                                                 : IW'(find_sum);
            x_nxt     = '0;
            res_nxt.status = ST_NOTFOUND;
            state_nxt = S_FRD;
          end
          default: ;
        endcase
      end
      S_RDWAIT: begin
        res_nxt.data_out = rdata;
        state_nxt        = S_DONE;
      end
      S_FRD: begin
        if ((x_r < req_r.amount) &&
            (WW'(req_r.start_offset) + WW'(x_r) < WW'(held_r))) begin
          raddr     = idx_r;
          state_nxt = S_FCMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FCMP: begin
        if (rdata == req_r.data_byte) begin
          res_nxt.status       = ST_OK;
          res_nxt.found_offset = 6'(x_r);
          state_nxt            = S_DONE;
        end else begin
          x_nxt     = x_r + 1'b1;
          idx_nxt   = next_slot(idx_r);
          state_nxt = S_FRD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_nxt            = res_r;
          out_nxt.fill_count = 7'(held_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= LAST;
      back_r      <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r <= idx_nxt;
    x_r   <= x_nxt;
    req_r <= req_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (held_r == '0) && (state_r == S_IDLE) && !out_valid_r, "reset did not empty the FIFO")
  `ASSERT_CLK(a_held_bound, WW'(held_r) <= WW'(DEPTH), "held count exceeds depth")
  `ASSERT_CLK(a_scan_bound, (state_r == S_FCMP) |-> (x_r < req_r.amount), "find compared past its length")
  `ASSERT_CLK(a_fill_report, out_load |=> out_valid_r && (out_r.fill_count == 7'(held_r)), "reported fill count differs from held count")

endmodule

>>> sv/brfs_store.sv
// ----------------------------------------------------------------------------
// brfs_store
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module brfs_store #(
  parameter int DEPTH = brfs_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte ring FIFO with search. A behavioral copy
// of the ring predicts every result word as each request word is accepted,
// and a monitor compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module tb;

  import brfs_pkg::*;

  localparam int RING_DEPTH  = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  // Sized for the slowest request word, a full-length find miss.
  localparam int SETTLE_CYCLES = 4 + 2 * RING_DEPTH;

  // Codes outside the defined set; the block treats them as no-ops.
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  byte_ring_fifo_with_search_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predicted ring contents. head_slot sits one slot before the oldest byte,
  // tail_slot is where the next enqueue lands.
  // --------------------------------------------------------------------------
  logic [7:0] ring_bytes [RING_DEPTH];
  int         head_slot  = RING_DEPTH - 1;
  int         tail_slot  = 0;
  int         ring_count = 0;

  out_word_t  pending_results [$];  // predicted result words, oldest first
  int         error_count   = 0;
  int         cycle_count   = 0;
  int         send_idle_pct = 0;    // chance per cycle that the sender holds off
  int         out_stall_pct = 0;    // chance per cycle that the receiver stalls
  bit         filling       = 1'b1; // random traffic drifts up or down in fill

  // Applies one request word to the predicted ring, returns its result word.
  function automatic out_word_t fifo_apply(in_word_t w);
    out_word_t r;
    int        slot;
    int        amt;
    int        start;
    r     = '0;
    amt   = int'(w.amount);
    start = int'(w.start_offset);
    r.status = ST_OK;
    case (w.opcode)
      OP_ENQ: begin
        if (ring_count >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_bytes[tail_slot] = w.data_byte;
          tail_slot  = (tail_slot + 1) % RING_DEPTH;
          ring_count = ring_count + 1;
        end
      end
      OP_DEQ: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_count = ring_count - 1;
          head_slot  = (head_slot + 1) % RING_DEPTH;
          r.data_out = ring_bytes[head_slot];
        end
      end
      OP_PEEK: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.data_out = ring_bytes[(head_slot + 1) % RING_DEPTH];
        end
      end
      OP_DISC: begin
        // Dropping everything (or more) resets both pointers.
        if (ring_count <= amt) begin
          head_slot  = RING_DEPTH - 1;
          tail_slot  = 0;
          ring_count = 0;
        end else begin
          head_slot  = (head_slot + amt) % RING_DEPTH;
          ring_count = ring_count - amt;
        end
      end
      OP_PUSH: begin
        if (ring_count >= RING_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring_bytes[head_slot] = w.data_byte;
          head_slot  = (head_slot == 0) ? RING_DEPTH - 1 : head_slot - 1;
          ring_count = ring_count + 1;
        end
      end
      OP_FIND: begin
        // Window stops at the search length or at the last held byte.
        r.status = ST_NOTFOUND;
        slot = (head_slot + 1 + start) % RING_DEPTH;
        for (int x = 0; x < amt && start + x < ring_count; x++) begin
          if (ring_bytes[slot] == w.data_byte) begin
            r.status       = ST_OK;
            r.found_offset = 6'(x);
            break;
          end
          slot = (slot + 1) % RING_DEPTH;
        end
      end
      default: begin
      end
    endcase
    r.fill_count = 7'(ring_count);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Called right after a rising edge; returns in the step of the edge
  // that accepted the word. in_valid stays high on return so back-to-back
  // words need no extra assignment in the same step.
  // --------------------------------------------------------------------------
  task automatic send_word(input in_word_t w);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(fifo_apply(w));
  endtask

  task automatic send_op(input logic [2:0] op, input logic [7:0] data,
                         input logic [6:0] amt, input logic [5:0] start);
    in_word_t w;
    w = '{opcode: op, data_byte: data, amount: amt, start_offset: start};
    send_word(w);
  endtask

  // Sender goes quiet until every predicted word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall, then compare each accepted word to the oldest
  // prediction. Values sampled at the edge are the pre-edge ones.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (out_stall_pct > 0) && ($urandom_range(99) < out_stall_pct);
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_word;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no prediction pending: %h", out_word);
        error_count++;
      end else begin
        exp_word = pending_results.pop_front();
        check_field("data_out", exp_word.data_out, out_word.data_out);
        check_field("status", exp_word.status, out_word.status);
        check_field("found_offset", exp_word.found_offset, out_word.found_offset);
        check_field("fill_count", exp_word.fill_count, out_word.fill_count);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("byte_ring_fifo_with_search_top verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Random request words. The fill level drifts between empty and full so
  // overflow, underflow and long finds all get exercised; finds usually aim
  // at a byte that is really held so hits are common.
  // --------------------------------------------------------------------------
  function automatic in_word_t make_random_word();
    in_word_t w;
    int       pick;
    int       enq_cut, push_cut, deq_cut, peek_cut, disc_cut;
    int       k;
    if (ring_count == 0) begin
      filling = 1'b1;
    end else if (ring_count == RING_DEPTH && $urandom_range(9) == 0) begin
      filling = 1'b0;
    end else if ($urandom_range(199) == 0) begin
      filling = !filling;
    end
    if (filling) begin
      enq_cut = 40; push_cut = 55; deq_cut = 63; peek_cut = 68; disc_cut = 73;
    end else begin
      enq_cut = 10; push_cut = 14; deq_cut = 44; peek_cut = 50; disc_cut = 68;
    end
    w.data_byte    = 8'($urandom_range(255));
    w.amount       = 7'($urandom_range(RING_DEPTH));
    w.start_offset = 6'($urandom_range(63));
    pick = $urandom_range(99);
    if (pick < enq_cut) begin
      w.opcode = OP_ENQ;
    end else if (pick < push_cut) begin
      w.opcode = OP_PUSH;
    end else if (pick < deq_cut) begin
      w.opcode = OP_DEQ;
    end else if (pick < peek_cut) begin
      w.opcode = OP_PEEK;
    end else if (pick < disc_cut) begin
      w.opcode = OP_DISC;
      // mostly short discards so the buffer does not empty every time
      if ($urandom_range(3) != 0) w.amount = 7'($urandom_range(3));
    end else if (pick < 97) begin
      w.opcode = OP_FIND;
      if (ring_count > 0 && $urandom_range(4) != 0) begin
        k = $urandom_range(ring_count - 1);
        w.start_offset = 6'($urandom_range(k));
        w.data_byte    = ring_bytes[(head_slot + 1 + k) % RING_DEPTH];
      end
    end else begin
      w.opcode = $urandom_range(1) ? OP_NOP6 : OP_NOP7;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Every read-type request on an empty ring, plus the unused codes.
  task automatic test_empty_buffer();
    send_op(OP_DEQ,  8'h00, 7'd0,  6'd0);
    send_op(OP_PEEK, 8'hFF, 7'd64, 6'd63);
    send_op(OP_FIND, 8'h00, 7'd64, 6'd0);
    send_op(OP_DISC, 8'h00, 7'd0,  6'd0);
    send_op(OP_NOP6, 8'hFF, 7'd64, 6'd63);
    send_op(OP_NOP7, 8'h5A, 7'd1,  6'd1);
  endtask

  // Dequeue walks the front to slot 0, so the next push back must wrap it
  // to the top of the ring. Finds cover zero length, a start past the fill
  // and a hit at the very start of the window.
  task automatic test_push_back_wrap();
    send_op(OP_ENQ,  8'h00, 7'd0,  6'd0);
    send_op(OP_ENQ,  8'hFF, 7'd0,  6'd0);
    send_op(OP_DEQ,  8'h00, 7'd0,  6'd0);
    send_op(OP_PUSH, 8'hA5, 7'd0,  6'd0);
    send_op(OP_PEEK, 8'h00, 7'd0,  6'd0);
    send_op(OP_FIND, 8'hFF, 7'd64, 6'd0);
    send_op(OP_FIND, 8'hFF, 7'd1,  6'd1);
    send_op(OP_FIND, 8'hFF, 7'd0,  6'd0);
    send_op(OP_FIND, 8'hA5, 7'd64, 6'd63);
    send_op(OP_DEQ,  8'h00, 7'd0,  6'd0);
    send_op(OP_DEQ,  8'h00, 7'd0,  6'd0);
    send_op(OP_DEQ,  8'h00, 7'd0,  6'd0);
  endtask

  // Partial discard moves the front; an oversize discard empties the ring.
  task automatic test_discard();
    send_op(OP_ENQ,  8'h11, 7'd0,  6'd0);
    send_op(OP_ENQ,  8'h22, 7'd0,  6'd0);
    send_op(OP_ENQ,  8'h33, 7'd0,  6'd0);
    send_op(OP_DISC, 8'h00, 7'd1,  6'd0);
    send_op(OP_PEEK, 8'h00, 7'd0,  6'd0);
    send_op(OP_DISC, 8'h00, 7'd64, 6'd0);
  endtask

  // Fill to capacity, then overflow both ends and search the whole ring.
  task automatic test_full_buffer();
    while (ring_count < RING_DEPTH) begin
      send_op(OP_ENQ, 8'($urandom_range(255)), 7'd0, 6'd0);
    end
    send_op(OP_ENQ,  8'h77, 7'd0,  6'd0);
    send_op(OP_PUSH, 8'h88, 7'd0,  6'd0);
    send_op(OP_FIND, ring_bytes[(head_slot + RING_DEPTH) % RING_DEPTH], 7'd64, 6'd63);
    send_op(OP_FIND, ring_bytes[(head_slot + 40) % RING_DEPTH], 7'd64, 6'd0);
    send_op(OP_DISC, 8'h00, 7'd63, 6'd0);
    send_op(OP_DISC, 8'h00, 7'd64, 6'd0);
  endtask

  task automatic test_random_traffic(input int n_words, input int idle_pct,
                                     input int stall_pct);
    send_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    repeat (n_words) send_word(make_random_word());
    // sender holds off until the block has returned everything
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) ring_bytes[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_buffer();
    test_push_back_wrap();
    test_discard();
    test_full_buffer();
    wait_drained();

    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 79, 0);
    test_random_traffic(350, 0, 79);
    test_random_traffic(350, 14, 14);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_ring_fifo_with_search_top verification clean");
    end else begin
      $display("byte_ring_fifo_with_search_top verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/brfs_pkg.sv
sv/brfs_store.sv
sv/byte_ring_fifo_with_search_top.sv
tb/sv/tb.sv
